@@ design/ofss_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ofss_pkg
// Shared types and constants for the oldest-first source select block.
// ----------------------------------------------------------------------------
package ofss_pkg;

  // field widths fixed by the interface
  localparam int unsigned OPW    = 3;
  localparam int unsigned SLOTW  = 4;
  localparam int unsigned STAMPW = 48;
  localparam int unsigned TICKW  = 20;

  // backoff value after reset
  localparam logic [TICKW-1:0] BACKOFF_RESET = 20'd60000;

  // operation codes
  typedef enum logic [OPW-1:0] {
    OP_ADD    = 3'd0,
    OP_REMOVE = 3'd1,
    OP_SELECT = 3'd2,
    OP_AFTER  = 3'd3,
    OP_TICK   = 3'd4
  } op_t;

  // top level sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } state_t;

  // status returned by the scan unit
  typedef struct packed {
    logic done;
    logic hit;
  } scan_stat_t;

endpackage : ofss_pkg
`default_nettype wire

@@ design/ofss_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ofss_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ofss_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule : ofss_ram
`default_nettype wire

@@ design/ofss_scan.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ofss_scan
// Walks all slots with one 48-bit comparator, keeping the oldest eligible
// slot seen so far; lowest index wins ties.
// ----------------------------------------------------------------------------
module ofss_scan #(
  parameter int unsigned SLOTS = 16,
  localparam int unsigned IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic                          elig,
  input  wire logic [ofss_pkg::STAMPW-1:0]   rd_data,
  output logic      [IW-1:0]                 rd_addr,
  output logic      [IW-1:0]                 best_idx,
  output ofss_pkg::scan_stat_t               stat
);

  localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

  logic                        issuing;
  logic [IW-1:0]               rd_cnt;
  logic                        cmp_valid;
  logic [IW-1:0]               cmp_idx;
  logic                        cmp_elig;
  logic                        hit;
  logic                        done;
  logic [ofss_pkg::STAMPW-1:0] best_stamp;
  logic                        take;

  assign rd_addr = rd_cnt;

  // the shared comparator
  assign take = cmp_valid && cmp_elig && (!hit || (rd_data < best_stamp));

  // read address sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      issuing   <= 1'b0;
      rd_cnt    <= '0;
      cmp_valid <= 1'b0;
      done      <= 1'b0;
    end else begin
      done      <= cmp_valid && (cmp_idx == LAST);
      cmp_valid <= issuing;
      if (start) begin
        issuing <= 1'b1;
        rd_cnt  <= '0;
      end else if (issuing) begin
        if (rd_cnt == LAST) begin
          issuing <= 1'b0;
        end else begin
          rd_cnt <= rd_cnt + 1'b1;
        end
      end
    end
  end

  // slot flags travel with the read to line up with the ram data
  always_ff @(posedge clk) begin
    cmp_idx  <= rd_cnt;
    cmp_elig <= elig;
  end

  // running best
  always_ff @(posedge clk) begin
    if (rst) begin
      hit <= 1'b0;
    end else if (start) begin
      hit <= 1'b0;
    end else if (take) begin
      hit <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx   <= cmp_idx;
      best_stamp <= rd_data;
    end
  end

  assign stat.done = done;
  assign stat.hit  = hit;

endmodule : ofss_scan
`default_nettype wire

@@ design/oldest_first_source_select_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// oldest_first_source_select_core
// Keeps a table of source slots and picks the oldest ready one on request.
//
// Input channel (in_valid / in_stall): one operation per transfer: add,
// remove, select, after read or tick. All operations except select give no
// result and leave the block ready for the next operation.
// A select walks every slot through one timestamp comparator, one slot per
// cycle, reading stamps from a RAM; its result (found, chosen_slot) is
// offered on the output channel (out_valid / out_stall) after the walk.
// in_stall is high for the whole walk, so a new select is taken only once
// the previous result sits in the output register. While the receiver
// stalls, other operations are still accepted, and a following select
// finishes its walk and then waits until the register is free.
// Reset (rst, synchronous) clears all slot flags, the tick counter and the
// backoff register (to 60000); timestamps are not cleared, no clearing pass.
// The backoff register is written through cfg_we / cfg_wdata; the user must
// do so only while idle, as the block itself does not enforce it.
// ----------------------------------------------------------------------------
module oldest_first_source_select_core #(
  parameter int unsigned SLOTS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // configuration
  input  wire logic                          cfg_we,
  input  wire logic [ofss_pkg::TICKW-1:0]    cfg_wdata,
  // input channel
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [ofss_pkg::OPW-1:0]      opcode,
  input  wire logic [ofss_pkg::SLOTW-1:0]    slot,
  input  wire logic [ofss_pkg::STAMPW-1:0]   stamp,
  input  wire logic                          got_record,
  // output channel
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               found,
  output logic      [ofss_pkg::SLOTW-1:0]    chosen_slot
);

  localparam int unsigned IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  ofss_pkg::state_t           state, state_next;
  logic [SLOTS-1:0]           present, present_next;
  logic [SLOTS-1:0]           ready, ready_next;
  logic [SLOTS-1:0]           empty, empty_next;
  logic [ofss_pkg::TICKW-1:0] elapsed, elapsed_next;
  logic [ofss_pkg::TICKW-1:0] backoff;

  logic                       in_xfer;
  logic                       out_xfer;
  logic                       slot_ok;
  logic [8:0]                 slot_wide;
  logic [IW-1:0]              slot_idx;
  logic                       ram_we;
  logic                       scan_start;
  logic                       restore;
  logic                       load_out;
  logic [IW-1:0]              rd_addr;
  logic [IW-1:0]              best_idx;
  logic [8:0]                 best_wide;
  logic [ofss_pkg::STAMPW-1:0] rd_data;
  ofss_pkg::scan_stat_t       stat;

  // handshakes
  assign in_stall = (state != ofss_pkg::ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid && !out_stall;

  // slot range check and table index
  assign slot_wide = {5'd0, slot};
  assign slot_ok   = (slot_wide < 9'(SLOTS));
  assign slot_idx  = slot_wide[IW-1:0];

  // timestamp writes: add, or after read with a record on a present slot
  always_comb begin
    ram_we = 1'b0;
    if (in_xfer && slot_ok) begin
      if (opcode == ofss_pkg::OP_ADD) begin
        ram_we = 1'b1;
      end else if (opcode == ofss_pkg::OP_AFTER && got_record && present[slot_idx]) begin
        ram_we = 1'b1;
      end
    end
  end

  ofss_ram #(
    .WIDTH (ofss_pkg::STAMPW),
    .DEPTH (SLOTS)
  ) u_stamp_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot_idx),
    .wdata (stamp),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign scan_start = in_xfer && (opcode == ofss_pkg::OP_SELECT);

  ofss_scan #(
    .SLOTS (SLOTS)
  ) u_scan (
    .clk      (clk),
    .rst      (rst),
    .start    (scan_start),
    .elig     (present[rd_addr] && ready[rd_addr]),
    .rd_data  (rd_data),
    .rd_addr  (rd_addr),
    .best_idx (best_idx),
    .stat     (stat)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ofss_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load_out   = 1'b0;
    restore    = 1'b0;
    unique case (state)
      ofss_pkg::ST_IDLE: begin
        if (scan_start) begin
          state_next = ofss_pkg::ST_SCAN;
        end
      end
      ofss_pkg::ST_SCAN: begin
        if (stat.done) begin
          restore = !stat.hit || (elapsed >= backoff);
          if (!out_valid || out_xfer) begin
            load_out   = 1'b1;
            state_next = ofss_pkg::ST_IDLE;
          end else begin
            state_next = ofss_pkg::ST_HOLD;
          end
        end
      end
      ofss_pkg::ST_HOLD: begin
        if (!out_valid || out_xfer) begin
          load_out   = 1'b1;
          state_next = ofss_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ofss_pkg::ST_IDLE;
      end
    endcase
  end

  // slot flags and tick counter
  always_comb begin
    present_next = present;
    ready_next   = ready;
    empty_next   = empty;
    elapsed_next = elapsed;
    if (in_xfer) begin
      unique case (opcode)
        ofss_pkg::OP_ADD: begin
          if (slot_ok) begin
            empty_next[slot_idx]   = 1'b0;
            present_next[slot_idx] = 1'b1;
            ready_next[slot_idx]   = 1'b1;
          end
        end
        ofss_pkg::OP_REMOVE: begin
          if (slot_ok) begin
            empty_next[slot_idx]   = 1'b0;
            present_next[slot_idx] = 1'b0;
            ready_next[slot_idx]   = 1'b0;
          end
        end
        ofss_pkg::OP_AFTER: begin
          if (slot_ok && present[slot_idx] && !got_record) begin
            empty_next[slot_idx] = 1'b1;
            ready_next[slot_idx] = 1'b0;
          end
        end
        ofss_pkg::OP_TICK: begin
          if (elapsed != '1) begin
            elapsed_next = elapsed + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    // retry emptied sources when a select finds nothing or the backoff is over
    if (restore) begin
      ready_next   = ready | (empty & present);
      empty_next   = '0;
      elapsed_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      present <= '0;
      ready   <= '0;
      empty   <= '0;
      elapsed <= '0;
    end else begin
      present <= present_next;
      ready   <= ready_next;
      empty   <= empty_next;
      elapsed <= elapsed_next;
    end
  end

  // backoff register
  always_ff @(posedge clk) begin
    if (rst) begin
      backoff <= ofss_pkg::BACKOFF_RESET;
    end else if (cfg_we) begin
      backoff <= cfg_wdata;
    end
  end

  // output register
  assign best_wide = 9'(best_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_xfer) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      found       <= stat.hit;
      chosen_slot <= stat.hit ? best_wide[ofss_pkg::SLOTW-1:0] : '0;
    end
  end

endmodule : oldest_first_source_select_core
`default_nettype wire

@@ dv/oldest_first_source_select_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// oldest_first_source_select_core_tb
// Drives add, remove, select, after-read and tick operations into the source
// table, keeps its own copy of the slot flags, stamps and tick counter, and
// checks every select answer against it in order. A short directed table is
// followed by random traffic over several backoff settings and idle patterns.
// ----------------------------------------------------------------------------
module oldest_first_source_select_core_tb;

  localparam int unsigned SLOTS        = 16;
  localparam int unsigned DRAIN_CYCLES = SLOTS + 8;
  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned MAX_REPORTS  = 10;
  localparam int unsigned PHASE_ITEMS  = 112;
  localparam int unsigned DIR_ROWS     = 25;

  localparam logic [ofss_pkg::STAMPW-1:0] STAMP_MAX = '1;
  localparam logic [ofss_pkg::TICKW-1:0]  TICK_MAX  = '1;

  // opcodes the block must ignore
  localparam logic [ofss_pkg::OPW-1:0] OP_RSVD5 = 3'd5;
  localparam logic [ofss_pkg::OPW-1:0] OP_RSVD6 = 3'd6;
  localparam logic [ofss_pkg::OPW-1:0] OP_RSVD7 = 3'd7;

  // one operation with an optional hand-written answer
  typedef struct packed {
    logic [ofss_pkg::OPW-1:0]    op;
    logic [ofss_pkg::SLOTW-1:0]  slot;
    logic [ofss_pkg::STAMPW-1:0] stamp;
    logic                        rec;
    logic                        pinned;
    logic                        pin_found;
    logic [ofss_pkg::SLOTW-1:0]  pin_slot;
  } src_op_t;

  typedef struct packed {
    logic                       found;
    logic [ofss_pkg::SLOTW-1:0] slot;
  } pick_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [ofss_pkg::TICKW-1:0] cfg_wdata;
  logic in_valid;
  logic in_stall;
  logic [ofss_pkg::OPW-1:0] opcode;
  logic [ofss_pkg::SLOTW-1:0] slot;
  logic [ofss_pkg::STAMPW-1:0] stamp;
  logic got_record;
  logic out_valid;
  logic out_stall;
  logic found;
  logic [ofss_pkg::SLOTW-1:0] chosen_slot;

  // shadow copy of the source table
  bit                          slot_on   [SLOTS];
  bit                          slot_rdy  [SLOTS];
  bit                          slot_dry  [SLOTS];
  logic [ofss_pkg::STAMPW-1:0] slot_time [SLOTS];
  logic [ofss_pkg::TICKW-1:0]  ticks_seen;
  logic [ofss_pkg::TICKW-1:0]  backoff_cfg;

  pick_t pick_q [$];
  int    fail_count    = 0;
  int    cycle_count   = 0;
  int    send_idle_pct = 0;
  int    recv_idle_pct = 0;

  oldest_first_source_select_core #(
    .SLOTS(SLOTS)
  ) u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .opcode     (opcode),
    .slot       (slot),
    .stamp      (stamp),
    .got_record (got_record),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .found      (found),
    .chosen_slot(chosen_slot)
  );

  // clock
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb: failure");
      $finish;
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(0, 99) < recv_idle_pct);
  end

  // compare each answer transfer with the oldest expected pick
  always @(posedge clk) begin : check_picks
    pick_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pick_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("unexpected pick: found %0b slot %0d", found, chosen_slot);
      end else begin
        want = pick_q.pop_front();
        if (found !== want.found || chosen_slot !== want.slot) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("pick mismatch: expected found %0b slot %0d, got found %0b slot %0d",
                     want.found, want.slot, found, chosen_slot);
        end
      end
    end
  end

  // send one operation, then update the shadow table on its transfer
  task automatic issue_source_op(input src_op_t r);
    bit    hit;
    int    best;
    pick_t got;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    opcode     <= r.op;
    slot       <= r.slot;
    stamp      <= r.stamp;
    got_record <= r.rec;
    do @(posedge clk); while (in_stall);

    case (r.op)
      ofss_pkg::OP_ADD: begin
        slot_dry[r.slot]  = 1'b0;
        slot_on[r.slot]   = 1'b1;
        slot_rdy[r.slot]  = 1'b1;
        slot_time[r.slot] = r.stamp;
      end
      ofss_pkg::OP_REMOVE: begin
        slot_dry[r.slot] = 1'b0;
        slot_on[r.slot]  = 1'b0;
        slot_rdy[r.slot] = 1'b0;
      end
      ofss_pkg::OP_SELECT: begin
        hit  = 1'b0;
        best = 0;
        // oldest ready slot, lowest index wins a tie
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_on[i] && slot_rdy[i] && (!hit || slot_time[i] < slot_time[best])) begin
            hit  = 1'b1;
            best = i;
          end
        end
        // nothing found or backoff over: retry emptied sources
        if (!hit || ticks_seen >= backoff_cfg) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (slot_dry[i] && slot_on[i]) slot_rdy[i] = 1'b1;
            slot_dry[i] = 1'b0;
          end
          ticks_seen = '0;
        end
        got.found = hit;
        got.slot  = hit ? ofss_pkg::SLOTW'(best) : '0;
        if (r.pinned) begin
          got.found = r.pin_found;
          got.slot  = r.pin_slot;
        end
        pick_q = {pick_q, got};
      end
      ofss_pkg::OP_AFTER: begin
        if (slot_on[r.slot]) begin
          if (r.rec) begin
            slot_time[r.slot] = r.stamp;
          end else begin
            slot_dry[r.slot] = 1'b1;
            slot_rdy[r.slot] = 1'b0;
          end
        end
      end
      ofss_pkg::OP_TICK: begin
        if (ticks_seen != TICK_MAX) ticks_seen++;
      end
      default: ;
    endcase
  endtask

  // write the backoff register once the block has gone quiet
  task automatic set_backoff(input logic [ofss_pkg::TICKW-1:0] v);
    @(negedge clk);
    in_valid <= 1'b0;
    while (pick_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    backoff_cfg = v;
  endtask

  initial begin
    src_op_t dir_rows [DIR_ROWS];
    src_op_t r;
    int      w;
    int      issued;

    rst        = 1'b1;
    cfg_we     = 1'b0;
    cfg_wdata  = '0;
    in_valid   = 1'b0;
    opcode     = ofss_pkg::OP_TICK;
    slot       = '0;
    stamp      = '0;
    got_record = 1'b0;
    out_stall  = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      slot_on[i]   = 1'b0;
      slot_rdy[i]  = 1'b0;
      slot_dry[i]  = 1'b0;
      slot_time[i] = '0;
    end
    ticks_seen  = '0;
    backoff_cfg = ofss_pkg::BACKOFF_RESET;

    // reset
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table: op, slot, stamp, record, pinned, found, chosen slot
    dir_rows[0]  = '{ofss_pkg::OP_SELECT, 4'd0,  48'd0,     1'b0, 1'b1, 1'b0, 4'd0};
    dir_rows[1]  = '{ofss_pkg::OP_ADD,    4'd0,  STAMP_MAX, 1'b0, 1'b0, 1'b0, 4'd0};
    dir_rows[2]  = '{ofss_pkg::OP_ADD,    4'd15, 48'd0,     1'b1, 1'b0, 1'b0, 4'd0};
    dir_rows[3]  = '{ofss_pkg::OP_SELECT, 4'd0,  48'd0,     1'b0, 1'b1, 1'b1, 4'd15};
    dir_rows[4]  = '{ofss_pkg::OP_AFTER,  4'd15, STAMP_MAX, 1'b1, 1'b0, 1'b0, 4'd0};
    dir_rows[5]  = '{ofss_pkg::OP_SELECT, 4'd0,  48'd0,     1'b0, 1'b1, 1'b1, 4'd0};
    dir_rows[6]  = '{ofss_pkg::OP_AFTER,  4'd0,  48'd0,     1'b0, 1'b0, 1'b0, 4'd0};
    dir_rows[7]  = '{ofss_pkg::OP_SELECT, 4'd0,  48'd0,     1'b0, 1'b1, 1'b1, 4'd15};
    dir_rows[8]  = '{ofss_pkg::OP_AFTER,  4'd15, 48'd0,     1'b0, 1'b0, 1'b0, 4'd0};
    dir_rows[9]  = '{ofss_pkg::OP_SELECT, 4'd0,  48'd0,     1'b0, 1'b1, 1'b0, 4'd0};
    dir_rows[10] = '{ofss_pkg::OP_SELECT, 4'd0,  48'd0,     1'b0, 1'b1, 1'b1, 4'd0};
    dir_rows[11] = '{ofss_pkg::OP_ADD,    4'd7,  48'd1,     1'b0, 1'b0, 1'b0, 4'd0};
    dir_rows[12] = '{ofss_pkg::OP_AFTER,  4'd7,  48'd0,     1'b0, 1'b0, 1'b0, 4'd0};
    dir_rows[13] = '{ofss_pkg::OP_REMOVE, 4'd7,  48'd0,     1'b0, 1'b0, 1'b0, 4'd0};
    // after read on an absent slot changes nothing
    dir_rows[14] = '{ofss_pkg::OP_AFTER,  4'd3,  48'd5,     1'b1, 1'b0, 1'b0, 4'd0};
    dir_rows[15] = '{ofss_pkg::OP_AFTER,  4'd3,  48'd0,     1'b0, 1'b0, 1'b0, 4'd0};
    dir_rows[16] = '{ofss_pkg::OP_TICK,   4'd0,  48'd0,     1'b0, 1'b0, 1'b0, 4'd0};
    // unknown opcodes are ignored
    dir_rows[17] = '{OP_RSVD5,            4'd1,  STAMP_MAX, 1'b1, 1'b0, 1'b0, 4'd0};
    dir_rows[18] = '{OP_RSVD6,            4'd2,  48'd0,     1'b0, 1'b0, 1'b0, 4'd0};
    dir_rows[19] = '{OP_RSVD7,            4'd15, STAMP_MAX, 1'b1, 1'b0, 1'b0, 4'd0};
    dir_rows[20] = '{ofss_pkg::OP_SELECT, 4'd0,  48'd0,     1'b0, 1'b0, 1'b0, 4'd0};
    dir_rows[21] = '{ofss_pkg::OP_ADD,    4'd8,  48'h8000_0000_0000, 1'b0, 1'b0, 1'b0, 4'd0};
    dir_rows[22] = '{ofss_pkg::OP_SELECT, 4'd0,  48'd0,     1'b0, 1'b0, 1'b0, 4'd0};
    dir_rows[23] = '{ofss_pkg::OP_REMOVE, 4'd8,  48'd0,     1'b0, 1'b0, 1'b0, 4'd0};
    dir_rows[24] = '{ofss_pkg::OP_SELECT, 4'd0,  48'd0,     1'b0, 1'b0, 1'b0, 4'd0};

    send_idle_pct = 37;
    recv_idle_pct = 67;
    foreach (dir_rows[k]) issue_source_op(dir_rows[k]);

    // random phases over backoff settings and idle patterns
    for (int p = 0; p < 6; p++) begin
      case (p)
        0: set_backoff(20'd1);
        1: set_backoff(20'd4);
        2: set_backoff(20'd0);
        3: set_backoff(TICK_MAX);
        4: set_backoff(20'd2);
        default: set_backoff(ofss_pkg::BACKOFF_RESET);
      endcase
      case (p / 2)
        0: begin
          send_idle_pct = 37;
          recv_idle_pct = 67;
        end
        1: begin
          send_idle_pct = 67;
          recv_idle_pct = 37;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase

      issued = 0;
      while (issued < PHASE_ITEMS) begin
        r.slot   = ofss_pkg::SLOTW'($urandom_range(0, SLOTS - 1));
        r.rec    = 1'($urandom_range(0, 1));
        r.pinned = 1'b0;
        r.pin_found = 1'b0;
        r.pin_slot  = '0;
        // mix of wide stamps, close stamps for ties and the top value
        w = $urandom_range(0, 99);
        if (w < 45)      r.stamp = ofss_pkg::STAMPW'({$urandom, $urandom});
        else if (w < 85) r.stamp = ofss_pkg::STAMPW'($urandom_range(0, 7));
        else             r.stamp = STAMP_MAX;
        w = $urandom_range(0, 99);
        if (w < 25)      r.op = ofss_pkg::OP_ADD;
        else if (w < 33) r.op = ofss_pkg::OP_REMOVE;
        else if (w < 53) r.op = ofss_pkg::OP_SELECT;
        else if (w < 78) r.op = ofss_pkg::OP_AFTER;
        else if (w < 95) r.op = ofss_pkg::OP_TICK;
        else             r.op = OP_WIDTH_PICK(w);
        if (r.op <= ofss_pkg::OP_TICK) issued++;
        issue_source_op(r);
      end
    end

    // drain
    @(negedge clk);
    in_valid <= 1'b0;
    while (pick_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pick_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // one of the ignored opcodes
  function automatic logic [ofss_pkg::OPW-1:0] OP_WIDTH_PICK(input int w);
    case (w % 3)
      0: return OP_RSVD5;
      1: return OP_RSVD6;
      default: return OP_RSVD7;
    endcase
  endfunction

endmodule

@@ files.f @@
design/ofss_pkg.sv
design/ofss_ram.sv
design/ofss_scan.sv
design/oldest_first_source_select_core.sv
dv/oldest_first_source_select_core_tb.sv
